// ----- hdl/csm_pkg.sv -----
package csm_pkg;

  localparam int MAX_ROWS  = 2048;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int NUM_PAIRS = 11;
  localparam int PAIR_W    = $clog2(NUM_PAIRS);
  localparam int EDGE_ROWS = 3;
  localparam int MIN_ROWS  = 2 * EDGE_ROWS + 1;
  localparam int SAMP_W    = 8;
  localparam int SQ_W      = 2 * SAMP_W + 1;
  localparam int SUM_W     = 27;
  localparam int SHIFT_W   = 4;

  localparam logic signed [SHIFT_W-1:0] SHORT_SHIFT = SHIFT_W'(6);

  typedef struct packed {
    logic                      done;
    logic signed [SHIFT_W-1:0] best_shift;
    logic [SUM_W-1:0]          best_sum;
  } csm_score_res_t;

  // row offset of column a for each pair
  function automatic logic signed [2:0] pair_shift_a(input logic [PAIR_W-1:0] k);
    logic signed [2:0] s;
    unique case (k)
      4'd0:    s = -3'sd3;
      4'd1:    s = -3'sd2;
      4'd2:    s = -3'sd1;
      4'd3:    s = -3'sd1;
      4'd4:    s = 3'sd0;
      4'd5:    s = 3'sd0;
      4'd6:    s = 3'sd1;
      4'd7:    s = 3'sd1;
      4'd8:    s = 3'sd2;
      4'd9:    s = 3'sd2;
      4'd10:   s = 3'sd3;
      default: s = 3'sd0;
    endcase
    return s;
  endfunction

  // row offset of column b for each pair
  function automatic logic signed [2:0] pair_shift_b(input logic [PAIR_W-1:0] k);
    logic signed [2:0] s;
    unique case (k)
      4'd0:    s = 3'sd3;
      4'd1:    s = 3'sd2;
      4'd2:    s = 3'sd2;
      4'd3:    s = 3'sd1;
      4'd4:    s = 3'sd1;
      4'd5:    s = 3'sd0;
      4'd6:    s = 3'sd0;
      4'd7:    s = -3'sd1;
      4'd8:    s = -3'sd1;
      4'd9:    s = -3'sd2;
      4'd10:   s = -3'sd3;
      default: s = 3'sd0;
    endcase
    return s;
  endfunction

  function automatic logic signed [SHIFT_W-1:0] pair_rel(input logic [PAIR_W-1:0] k);
    return SHIFT_W'(pair_shift_b(k)) - SHIFT_W'(pair_shift_a(k));
  endfunction

endpackage

// ----- hdl/csm_score.sv -----
module csm_score
  import csm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [ROW_W-1:0]      wr_addr,
  input  logic [SAMP_W-1:0]     wr_a,
  input  logic [SAMP_W-1:0]     wr_b,
  input  logic                  start,
  input  logic [CNT_W-1:0]      rows,
  output csm_score_res_t        res
);

  logic [SAMP_W-1:0] mem_a [MAX_ROWS];
  logic [SAMP_W-1:0] mem_b [MAX_ROWS];

  logic                  iss_act_r;
  logic [PAIR_W-1:0]     k_r;
  logic [ROW_W-1:0]      y_r;
  logic [CNT_W-1:0]      rows_r;
  logic [CNT_W-1:0]      y_last;
  logic                  y_at_first;
  logic                  y_at_last;
  logic [CNT_W-1:0]      addr_a_full;
  logic [CNT_W-1:0]      addr_b_full;

  logic [SAMP_W-1:0]     rd_a_r;
  logic [SAMP_W-1:0]     rd_b_r;
  logic                  s1_vld_r;
  logic                  s1_first_r;
  logic                  s1_last_r;
  logic [PAIR_W-1:0]     s1_k_r;

  logic signed [SAMP_W:0]     diff;
  logic signed [2*SAMP_W+1:0] prod;
  logic [SQ_W-1:0]       sq_r;
  logic                  s2_vld_r;
  logic                  s2_first_r;
  logic                  s2_last_r;
  logic [PAIR_W-1:0]     s2_k_r;

  logic [SUM_W:0]        acc_sum;
  logic [SUM_W-1:0]      acc_r;
  logic                  s3_last_r;
  logic [PAIR_W-1:0]     s3_k_r;

  logic [SUM_W-1:0]          best_sum_r;
  logic signed [SHIFT_W-1:0] best_shift_r;
  logic                      done_r;

  assign y_last      = rows_r - CNT_W'(EDGE_ROWS + 1);
  assign y_at_first  = (y_r == ROW_W'(EDGE_ROWS));
  assign y_at_last   = ({1'b0, y_r} == y_last);
  assign addr_a_full = {1'b0, y_r} + CNT_W'(pair_shift_a(k_r));
  assign addr_b_full = {1'b0, y_r} + CNT_W'(pair_shift_b(k_r));

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
    rd_a_r <= mem_a[addr_a_full[ROW_W-1:0]];
    rd_b_r <= mem_b[addr_b_full[ROW_W-1:0]];
  end

  // row and pair sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
      k_r       <= '0;
      y_r       <= ROW_W'(EDGE_ROWS);
    end else if (start) begin
      iss_act_r <= 1'b1;
      k_r       <= '0;
      y_r       <= ROW_W'(EDGE_ROWS);
    end else if (iss_act_r) begin
      if (y_at_last) begin
        y_r <= ROW_W'(EDGE_ROWS);
        if (k_r == PAIR_W'(NUM_PAIRS - 1)) begin
          iss_act_r <= 1'b0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end else begin
        y_r <= y_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rows_r <= rows;
    end
  end

  assign diff = $signed({1'b0, rd_a_r}) - $signed({1'b0, rd_b_r});
  assign prod = diff * diff;
  assign acc_sum = {1'b0, acc_r} + (SUM_W + 1)'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      s1_vld_r  <= iss_act_r;
      s2_vld_r  <= s1_vld_r;
      s3_last_r <= s2_vld_r && s2_last_r;
      done_r    <= s3_last_r && (s3_k_r == PAIR_W'(NUM_PAIRS - 1));
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= y_at_first;
    s1_last_r  <= y_at_last;
    s1_k_r     <= k_r;
    sq_r       <= prod[SQ_W-1:0];
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_k_r     <= s1_k_r;
    s3_k_r     <= s2_k_r;
    if (s2_vld_r) begin
      if (s2_first_r) begin
        acc_r <= SUM_W'(sq_r);
      end else if (acc_sum[SUM_W]) begin
        acc_r <= '1;
      end else begin
        acc_r <= acc_sum[SUM_W-1:0];
      end
    end
    // first minimum wins
    if (s3_last_r && ((s3_k_r == '0) || (acc_r < best_sum_r))) begin
      best_sum_r   <= acc_r;
      best_shift_r <= pair_rel(s3_k_r);
    end
  end

  assign res.done       = done_r;
  assign res.best_shift = best_shift_r;
  assign res.best_sum   = best_sum_r;

endmodule

// ----- hdl/column_shift_ssd_match.sv -----
// Column-pair vertical shift matcher. Rows of two gradient columns load one
// beat per cycle into two on-chip stores; the beat flagged last_row is itself
// a row and starts scoring. Scoring walks one shared subtract/square/accumulate
// unit over rows 3 .. rows-4 for each of 11 shift pairs, one row a cycle, when a
// column has R >= 7 rows; shorter columns report shift 6 with sum 0 at once.
// The input is not ready while scoring or while a finished result waits for
// the output register to free up. Up to 2048 rows are stored; further rows
// are dropped but a last_row beat still triggers scoring.
module column_shift_ssd_match
  import csm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMP_W-1:0]         in_sample_a,
  input  logic [SAMP_W-1:0]         in_sample_b,
  input  logic                      in_last_row,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SHIFT_W-1:0] out_best_shift,
  output logic [SUM_W-1:0]          out_best_sum
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SCORE = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;

  logic [1:0]                state_r;
  logic [1:0]                state_nxt;
  logic [CNT_W-1:0]          row_cnt_r;
  logic [CNT_W-1:0]          row_cnt_nxt;
  logic                      short_r;
  logic                      short_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic signed [SHIFT_W-1:0] out_shift_r;
  logic [SUM_W-1:0]          out_sum_r;

  logic                      in_acc;
  logic                      full;
  logic [CNT_W-1:0]          rows_eff;
  logic                      is_short;
  logic                      start;
  logic                      out_load;
  csm_score_res_t            res;

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = (row_cnt_r == CNT_W'(MAX_ROWS));
  assign rows_eff = full ? row_cnt_r : row_cnt_r + 1'b1;
  assign is_short = (rows_eff < CNT_W'(MIN_ROWS));
  assign start    = in_acc && in_last_row && !is_short;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  csm_score u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && !full),
    .wr_addr (row_cnt_r[ROW_W-1:0]),
    .wr_a    (in_sample_a),
    .wr_b    (in_sample_b),
    .start   (start),
    .rows    (rows_eff),
    .res     (res)
  );

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    short_nxt     = short_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (in_last_row) begin
            row_cnt_nxt = '0;
            short_nxt   = is_short;
            state_nxt   = is_short ? ST_OUT : ST_SCORE;
          end else begin
            row_cnt_nxt = rows_eff;
          end
        end
      end
      ST_SCORE: begin
        if (res.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      row_cnt_r   <= '0;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      short_r     <= short_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // short column reports the first pair with a zero sum
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_shift_r <= short_r ? SHORT_SHIFT : res.best_shift;
      out_sum_r   <= short_r ? '0 : res.best_sum;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_shift = out_shift_r;
  assign out_best_sum   = out_sum_r;

endmodule
